// ===== hw/rtl/ssd_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ssd_pkg: shared types and constants of the seven segment digit renderer
// request structs, the segment decode table, register indexes and codes
// ----------------------------------------------------------------------------
package ssd_pkg;

  // one input request: digit and its screen origin
  typedef struct packed {
    logic [9:0] origin_x;
    logic [9:0] origin_y;
    logic [3:0] digit;
  } in_t;

  // one rectangle command
  typedef struct packed {
    logic signed [11:0] rect_x0;
    logic signed [11:0] rect_y0;
    logic signed [11:0] rect_x1;
    logic signed [11:0] rect_y1;
    logic [15:0]        fill_color;
    logic               last_rect;
  } out_t;

  // classified digit, as held in the queue
  typedef struct packed {
    logic [9:0] ox;
    logic [9:0] oy;
    logic [6:0] segs;
  } job_t;

  // queue entry offer: valid plus payload
  typedef struct packed {
    logic valid;
    job_t job;
  } job_req_t;

  // register indexes
  localparam logic REG_COLOR_ON  = 1'b0;
  localparam logic REG_COLOR_OFF = 1'b1;

  localparam logic [15:0] COLOR_ON_RESET  = 16'd2047;
  localparam logic [15:0] COLOR_OFF_RESET = 16'd2113;

  // segment indexes in drawing order
  localparam logic [2:0] SEG_A = 3'd0;
  localparam logic [2:0] SEG_B = 3'd1;
  localparam logic [2:0] SEG_C = 3'd2;
  localparam logic [2:0] SEG_D = 3'd3;
  localparam logic [2:0] SEG_E = 3'd4;
  localparam logic [2:0] SEG_F = 3'd5;
  localparam logic [2:0] SEG_G = 3'd6;

  // bars A, D and G run horizontally
  localparam logic [6:0] HORIZ_MASK = 7'b1001001;

  // standard decode, bit 0 is segment A; codes above nine are blank
  function automatic logic [6:0] seg_decode(input logic [3:0] digit);
    logic [6:0] segs;
    unique case (digit)
      4'd0:    segs = 7'h3f;
      4'd1:    segs = 7'h06;
      4'd2:    segs = 7'h5b;
      4'd3:    segs = 7'h4f;
      4'd4:    segs = 7'h66;
      4'd5:    segs = 7'h6d;
      4'd6:    segs = 7'h7d;
      4'd7:    segs = 7'h07;
      4'd8:    segs = 7'h7f;
      4'd9:    segs = 7'h6f;
      default: segs = 7'h00;
    endcase
    return segs;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/ssd_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ssd_front: input stage
// accepts digit requests, decodes the segment mask and offers the result to
// the queue
// ----------------------------------------------------------------------------
module ssd_front (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire ssd_pkg::in_t     in_data,
  output ssd_pkg::job_req_t     push,
  input  wire logic             q_full
);
  import ssd_pkg::*;

  logic front_valid_r, front_valid_nxt;
  job_t job_r;
  logic accept, push_fire;

  // hold off new requests only while the staged one cannot move on
  assign in_stall  = front_valid_r && q_full;
  assign accept    = in_valid && !in_stall;
  assign push_fire = front_valid_r && !q_full;

  always_comb begin
    front_valid_nxt = front_valid_r;
    if (accept) begin
      front_valid_nxt = 1'b1;
    end else if (push_fire) begin
      front_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_valid_r <= 1'b0;
    end else begin
      front_valid_r <= front_valid_nxt;
    end
  end

  // classify: decode the digit once on the way in
  always_ff @(posedge clk) begin
    if (accept) begin
      job_r.ox   <= in_data.origin_x;
      job_r.oy   <= in_data.origin_y;
      job_r.segs <= seg_decode(in_data.digit);
    end
  end

  assign push.valid = front_valid_r;
  assign push.job   = job_r;

endmodule
`default_nettype wire

// ===== hw/rtl/ssd_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ssd_queue: two-entry queue between front and back
// lets the input side take a digit while the back is still drawing
// ----------------------------------------------------------------------------
module ssd_queue (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire ssd_pkg::job_req_t push,
  output logic                   full,
  output ssd_pkg::job_req_t      head,
  input  wire logic              pop
);
  import ssd_pkg::*;

  job_t       mem [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       do_push, do_pop;

  assign full    = (count_r == 2'd2);
  assign do_push = push.valid && !full;
  assign do_pop  = pop && (count_r != 2'd0);

  // pointer and fill bookkeeping
  always_comb begin
    wr_ptr_nxt = do_push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 2'd1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push.job;
    end
  end

  assign head.valid = (count_r != 2'd0);
  assign head.job   = mem[rd_ptr_r];

endmodule
`default_nettype wire

// ===== hw/rtl/ssd_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ssd_back: rectangle sequencer
// walks segments A to G and the lines of each bar, one rectangle per cycle
// while the output is not stalled, into the output register
// ----------------------------------------------------------------------------
module ssd_back #(
  parameter int SEG_LEN   = 30,
  parameter int SEG_WIDTH = 6,
  parameter int SEG_GAP   = 2
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire ssd_pkg::job_req_t head,
  output logic                   pop,
  input  wire logic [15:0]       color_on,
  input  wire logic [15:0]       color_off,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output ssd_pkg::out_t          out_data
);
  import ssd_pkg::*;

  localparam int IW = (SEG_WIDTH > 1) ? $clog2(SEG_WIDTH) : 1;
  localparam int W2 = SEG_WIDTH / 2;

  localparam logic [IW-1:0] LAST_I = IW'(SEG_WIDTH - 1);
  localparam logic [11:0]   W2_C   = 12'(W2);
  localparam logic [11:0]   H_C    = 12'(SEG_LEN - SEG_GAP);

  // bar base offsets from the origin
  localparam logic [11:0] OFF_X_MID   = 12'(W2 + SEG_GAP);
  localparam logic [11:0] OFF_X_RIGHT = 12'(SEG_LEN + SEG_GAP);
  localparam logic [11:0] OFF_Y_TOP   = 12'(-(W2 + SEG_LEN + SEG_GAP));
  localparam logic [11:0] OFF_Y_UPPER = 12'(-SEG_LEN);
  localparam logic [11:0] OFF_Y_LOWER = 12'(SEG_GAP);
  localparam logic [11:0] OFF_Y_BOT   = 12'(SEG_LEN + SEG_GAP - W2);
  localparam logic [11:0] OFF_Y_MID   = 12'(-W2);

  logic          busy_r, busy_nxt;
  job_t          job_r;
  logic [2:0]    s_r, s_nxt;
  logic [IW-1:0] i_r, i_nxt;
  logic          out_valid_r, out_valid_nxt;
  out_t          out_r;

  logic          load_ok, emit, last_now;
  logic [11:0]   off_x, off_y, base_x, base_y, i_ext, d;
  logic [11:0]   x0, y0, x1, y1;
  out_t          rect;

  assign load_ok  = !out_valid_r || !out_stall;
  assign emit     = busy_r && load_ok;
  assign last_now = (s_r == SEG_G) && (i_r == LAST_I);
  assign pop      = head.valid && (!busy_r || (emit && last_now));

  // base of the current bar
  always_comb begin
    unique case (s_r)
      SEG_A:   begin off_x = OFF_X_MID;   off_y = OFF_Y_TOP;   end
      SEG_B:   begin off_x = OFF_X_RIGHT; off_y = OFF_Y_UPPER; end
      SEG_C:   begin off_x = OFF_X_RIGHT; off_y = OFF_Y_LOWER; end
      SEG_D:   begin off_x = OFF_X_MID;   off_y = OFF_Y_BOT;   end
      SEG_E:   begin off_x = 12'd0;       off_y = OFF_Y_LOWER; end
      SEG_F:   begin off_x = 12'd0;       off_y = OFF_Y_UPPER; end
      SEG_G:   begin off_x = OFF_X_MID;   off_y = OFF_Y_MID;   end
      default: begin off_x = 12'd0;       off_y = 12'd0;       end
    endcase
  end

  // one line of the bevelled bar
  always_comb begin
    base_x = {2'b00, job_r.ox} + off_x;
    base_y = {2'b00, job_r.oy} + off_y;
    i_ext  = {{(12 - IW){1'b0}}, i_r};
    d      = (i_ext < W2_C) ? (W2_C - i_ext) : (i_ext - W2_C);
    if (HORIZ_MASK[s_r]) begin
      x0 = base_x + d;
      x1 = base_x + H_C - d;
      y0 = base_y + i_ext;
      y1 = y0;
    end else begin
      x0 = base_x + i_ext;
      x1 = x0;
      y0 = base_y + d;
      y1 = base_y + H_C - d;
    end
    rect.rect_x0    = $signed(x0);
    rect.rect_y0    = $signed(y0);
    rect.rect_x1    = $signed(x1);
    rect.rect_y1    = $signed(y1);
    rect.fill_color = job_r.segs[s_r] ? color_on : color_off;
    rect.last_rect  = last_now;
  end

  // sequencer counters
  always_comb begin
    busy_nxt = busy_r;
    s_nxt    = s_r;
    i_nxt    = i_r;
    if (emit) begin
      if (i_r == LAST_I) begin
        i_nxt = '0;
        s_nxt = last_now ? SEG_A : s_r + 3'd1;
      end else begin
        i_nxt = i_r + IW'(1);
      end
      if (last_now) begin
        busy_nxt = 1'b0;
      end
    end
    if (pop) begin
      busy_nxt = 1'b1;
      s_nxt    = SEG_A;
      i_nxt    = '0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      s_r         <= SEG_A;
      i_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      s_r         <= s_nxt;
      i_r         <= i_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (pop) begin
      job_r <= head.job;
    end
    if (emit) begin
      out_r <= rect;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // a rectangle that is not the last keeps the sequencer busy
  a_busy_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && !last_now) |=> busy_r)
    else $error("sequencer dropped a digit mid-draw");

  // line counter stays inside the bar
  a_line_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (i_r <= LAST_I && s_r <= SEG_G))
    else $error("line or segment counter out of range");

  // every rectangle is a single line
  a_one_line: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_r.rect_x0 == out_r.rect_x1 || out_r.rect_y0 == out_r.rect_y1))
    else $error("rectangle wider than one pixel");

  // fill is one of the two programmed colors
  a_color: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_r.fill_color == color_on || out_r.fill_color == color_off))
    else $error("fill color not from a color register");

endmodule
`default_nettype wire

// ===== hw/rtl/seven_segment_digit_renderer.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// seven_segment_digit_renderer: bevelled seven segment digit to rectangles
// Input requests carry a digit (0..9, larger codes draw blank) and an origin.
// Each digit turns into 7*SEG_WIDTH one-pixel line rectangles (42 at the
// default width), segments A to G, each filled with the on or off color; the
// last one of a digit has last_rect set.
// Channels use valid/stall; a request moves when valid is high and stall low.
// The register port is APB-style: color_on at 0x0, color_off at 0x4; the user
// must write them only while the block is idle (not enforced); always ready.
// The first rectangle of a digit passes the input stage register, the queue,
// the sequencer and the output register. The back sequencer emits one
// rectangle per cycle while the output is not stalled; a
// two-entry queue behind the input stage lets new digits be taken while one
// is being drawn.
// When the receiver stalls, the output register holds its rectangle and the
// sequencer waits; the queue fills and then the input stalls.
// Reset (synchronous, rst_n low) empties all stages and loads the reset
// colors.
// ----------------------------------------------------------------------------
module seven_segment_digit_renderer #(
  parameter int SEG_LEN   = 30,
  parameter int SEG_WIDTH = 6,
  parameter int SEG_GAP   = 2
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire ssd_pkg::in_t  in_data,
  output logic               out_valid,
  input  wire logic          out_stall,
  output ssd_pkg::out_t      out_data,
  input  wire logic          psel,
  input  wire logic          penable,
  input  wire logic          pwrite,
  input  wire logic [2:0]    paddr,
  input  wire logic [31:0]   pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import ssd_pkg::*;

  logic [15:0] color_on_r, color_on_nxt;
  logic [15:0] color_off_r, color_off_nxt;
  logic        wr_en;
  job_req_t    push, head;
  logic        q_full, pop;

  // color registers
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_comb begin
    color_on_nxt  = color_on_r;
    color_off_nxt = color_off_r;
    if (wr_en) begin
      unique case (paddr[2])
        REG_COLOR_ON:  color_on_nxt  = pwdata[15:0];
        REG_COLOR_OFF: color_off_nxt = pwdata[15:0];
        default:       color_on_nxt  = color_on_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      color_on_r  <= COLOR_ON_RESET;
      color_off_r <= COLOR_OFF_RESET;
    end else begin
      color_on_r  <= color_on_nxt;
      color_off_r <= color_off_nxt;
    end
  end

  // read back
  assign prdata = {16'h0000, (paddr[2] == REG_COLOR_OFF) ? color_off_r : color_on_r};

  ssd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .push     (push),
    .q_full   (q_full)
  );

  ssd_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .full  (q_full),
    .head  (head),
    .pop   (pop)
  );

  ssd_back #(
    .SEG_LEN   (SEG_LEN),
    .SEG_WIDTH (SEG_WIDTH),
    .SEG_GAP   (SEG_GAP)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .pop       (pop),
    .color_on  (color_on_r),
    .color_off (color_off_r),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire
